// ===== rtl/core/n_queens_backtrack_solver_defines.svh =====
// Assertion macros used by the checker file of the solver.
`ifndef N_QUEENS_BACKTRACK_SOLVER_DEFINES_SVH
`define N_QUEENS_BACKTRACK_SOLVER_DEFINES_SVH

// A property that must hold at every clock edge once reset is released.
`define NQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true once reset is released.
`define NQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/nq_pkg.sv =====
package nq_pkg;

  // Width of the board size and queen column fields on the ports.
  localparam int FIELD_W = 5;

  // Default largest board that fits the row store.
  localparam int MAX_N_DEFAULT = 16;

endpackage

// ===== rtl/core/nq_in_if.sv =====
interface nq_in_if;
  logic                       valid;
  logic                       ready;
  logic [nq_pkg::FIELD_W-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink (input valid, input board_size, output ready);
endinterface

// ===== rtl/core/nq_out_if.sv =====
interface nq_out_if;
  logic                       valid;
  logic                       ready;
  logic [nq_pkg::FIELD_W-1:0] queen_column;
  logic                       found;
  logic                       last;

  modport source (output valid, output queen_column, output found, output last, input ready);
  modport sink (input valid, input queen_column, input found, input last, output ready);
endinterface

// ===== rtl/core/nq_clash_unit.sv =====
// Shared compare unit: does a candidate column clash with one earlier queen?
// A clash is a shared column or a column distance equal to the row distance.
module nq_clash_unit #(
  parameter int CW = 5,
  parameter int RW = 4
) (
  input  logic [CW-1:0] cand_col,
  input  logic [CW-1:0] other_col,
  input  logic [RW-1:0] row_dist,
  output logic          clash
);

  localparam int DW = (CW > RW) ? CW : RW;

  logic [CW-1:0] col_dist;

  assign col_dist = (cand_col > other_col) ? (cand_col - other_col) : (other_col - cand_col);
  assign clash    = (col_dist == '0) || (DW'(col_dist) == DW'(row_dist));

endmodule

// ===== rtl/core/n_queens_backtrack_solver.sv =====
// Channel   Dir  Fields                            Word
// in_chan   in   board_size[4:0]                   one board size N
// out_chan  out  queen_column[4:0], found, last    one row's queen column
//
// Each candidate column is tried, then checked in the shared clash unit against
// the earlier rows in turn until one clashes or all pass; the search time is set
// by the backtracking path. Each result word is read from the store, then held in
// the output register. rst_n is synchronous, active low and clears all control
// state. A stall on out_chan holds the word and the search state; in_chan.ready
// is high only while the block is idle.
module n_queens_backtrack_solver #(
  parameter int MAX_N = nq_pkg::MAX_N_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  nq_in_if.sink     in_chan,
  nq_out_if.source  out_chan
);

  localparam int FW = nq_pkg::FIELD_W;
  // Column counter reaches N + 1 when a row runs out of columns.
  localparam int CW = $clog2(MAX_N + 2);
  // Row index into the store.
  localparam int RW = $clog2(MAX_N);
  // Common width for comparisons of columns, rows and N.
  localparam int XW = (CW > FW) ? CW : FW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_CHECK,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [FW-1:0]  n_r, n_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  k_r, k_nxt;
  logic [RW-1:0]  emit_row_r, emit_row_nxt;
  logic [FW-1:0]  out_col_r, out_col_nxt;
  logic           out_found_r, out_found_nxt;
  logic           out_last_r, out_last_nxt;

  // Chosen column per row. Each row is written before it is ever read.
  logic [CW-1:0]  col_store [MAX_N];
  logic           wr_en;
  logic [RW-1:0]  rd_addr_nxt;
  logic [CW-1:0]  rd_col_r;
  logic           clash;
  logic           row_done;

  // The store has one registered read port. The address follows the state the
  // block is about to enter, so the entry is ready in the cycle that uses it.
  always_comb begin
    unique case (state_nxt)
      S_TRY:   rd_addr_nxt = row_nxt - RW'(1);
      S_CHECK: rd_addr_nxt = k_nxt;
      default: rd_addr_nxt = emit_row_nxt;
    endcase
  end

  nq_clash_unit #(
    .CW (CW),
    .RW (RW)
  ) u_clash (
    .cand_col  (col_r),
    .other_col (rd_col_r),
    .row_dist  (row_r - k_r),
    .clash     (clash)
  );

  // True when the row being placed is the last row of the board.
  assign row_done = (XW'(row_r) + XW'(1)) == XW'(n_r);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    emit_row_nxt  = emit_row_r;
    out_col_nxt   = out_col_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          n_nxt        = in_chan.board_size;
          emit_row_nxt = '0;
          if ((in_chan.board_size == '0) || (XW'(in_chan.board_size) > XW'(MAX_N))) begin
            // Empty board or a board larger than the store: report no placement.
            out_col_nxt   = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            row_nxt   = '0;
            col_nxt   = CW'(1);
            state_nxt = S_TRY;
          end
        end
      end

      S_TRY: begin
        if (XW'(col_r) > XW'(n_r)) begin
          if (row_r == '0) begin
            // The first row ran out of columns: the board has no solution.
            out_col_nxt   = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            // Backtrack and move the previous row's queen one column on.
            row_nxt = row_r - RW'(1);
            col_nxt = rd_col_r + CW'(1);
          end
        end else if (row_r == '0) begin
          // The first row has nothing to clash with.
          wr_en = 1'b1;
          if (row_done) begin
            state_nxt = S_LOAD;
          end else begin
            row_nxt = row_r + RW'(1);
            col_nxt = CW'(1);
          end
        end else begin
          k_nxt     = '0;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (clash) begin
          col_nxt   = col_r + CW'(1);
          state_nxt = S_TRY;
        end else if (k_r == (row_r - RW'(1))) begin
          // Every earlier queen checked: keep this column.
          wr_en = 1'b1;
          if (row_done) begin
            state_nxt = S_LOAD;
          end else begin
            row_nxt   = row_r + RW'(1);
            col_nxt   = CW'(1);
            state_nxt = S_TRY;
          end
        end else begin
          k_nxt = k_r + RW'(1);
        end
      end

      S_LOAD: begin
        out_col_nxt   = FW'(rd_col_r);
        out_found_nxt = 1'b1;
        out_last_nxt  = (XW'(emit_row_r) + XW'(1)) == XW'(n_r);
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (out_chan.ready) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            emit_row_nxt = emit_row_r + RW'(1);
            state_nxt    = S_LOAD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      emit_row_r  <= '0;
      out_col_r   <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
      emit_row_r  <= emit_row_nxt;
      out_col_r   <= out_col_nxt;
      out_found_r <= out_found_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_store[row_r] <= col_r;
    end
    // A row written at this edge is passed straight to the read port.
    if (wr_en && (row_r == rd_addr_nxt)) begin
      rd_col_r <= col_r;
    end else begin
      rd_col_r <= col_store[rd_addr_nxt];
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_EMIT);
  assign out_chan.queen_column = out_col_r;
  assign out_chan.found        = out_found_r;
  assign out_chan.last         = out_last_r;

endmodule

// ===== rtl/core/nq_checker.sv =====
`include "n_queens_backtrack_solver_defines.svh"

// Port-level checks on the solver.
module nq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_queen_column,
  input logic       out_found,
  input logic       out_last
);

  logic [6:0] out_word;
  logic       out_stall;
  logic       out_fail;
  logic       fail_ok;
  logic       out_end;

  assign out_word  = {out_queen_column, out_found, out_last};
  assign out_stall = out_valid && !out_ready;
  assign out_fail  = out_valid && !out_found;
  assign fail_ok   = out_last && (out_queen_column == 5'd0);
  assign out_end   = out_valid && out_ready && out_last;

  // The block never takes a new board while a word is waiting.
  `NQ_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "ready while a word is pending")

  // A stalled word keeps its contents.
  `NQ_ASSERT(a_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word), "stalled word changed")

  // A failed search is reported as one final word with a zero column.
  `NQ_ASSERT(a_fail_form, clk, rst_n, out_fail |-> fail_ok, "malformed no-placement word")

  // After the final word is taken, the block goes idle and waits for a board.
  `NQ_ASSERT(a_end_idle, clk, rst_n, out_end |=> !out_valid && in_ready, "busy after last word")

endmodule

bind n_queens_backtrack_solver nq_checker u_nq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_queen_column (out_chan.queen_column),
  .out_found        (out_chan.found),
  .out_last         (out_chan.last)
);
